FILE: hdl/e2q_pkg.sv
// Shared types and constants for the Euler angle to quaternion converter.
`default_nettype none

package e2q_pkg;

   localparam int ANGLE_W  = 16;
   localparam int QUAT_W   = 16;
   localparam int CORDIC_W = 34;
   localparam int MUL_W    = 32;
   localparam int PROD_W   = 64;
   localparam int SUM_W    = 65;
   localparam int Q_FRAC   = 30;
   localparam int NUM_LANES = 3;
   localparam int TABLE_LEN = 24;

   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   typedef logic signed [ANGLE_W-1:0]  angle_type;
   typedef logic signed [QUAT_W-1:0]   quat_type;
   typedef logic signed [CORDIC_W-1:0] cordic_type;
   typedef logic signed [MUL_W-1:0]    mul_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;
   localparam cordic_type INV_GAIN_Q30 = 34'sd652032874;

   localparam logic signed [31:0] ATAN_Q30 [TABLE_LEN] = '{
      32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
      32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
      32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
      32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
      32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
      32'sd1024,      32'sd512,       32'sd256,       32'sd128
   };

endpackage

`default_nettype wire

FILE: hdl/e2q_if.sv
// Beat interfaces for the angle request channel and the quaternion response channel.
`default_nettype none

interface e2q_req_if import e2q_pkg::*;;
   logic      valid;
   logic      ready;
   angle_type angle_x;
   angle_type angle_y;
   angle_type angle_z;

   modport source (output valid, output angle_x, output angle_y, output angle_z,
                   input ready);
   modport sink (input valid, input angle_x, input angle_y, input angle_z,
                 output ready);
endinterface

interface e2q_rsp_if import e2q_pkg::*;;
   logic     valid;
   logic     ready;
   quat_type quat_x;
   quat_type quat_y;
   quat_type quat_z;
   quat_type quat_w;

   modport source (output valid, output quat_x, output quat_y, output quat_z,
                   output quat_w, input ready);
   modport sink (input valid, input quat_x, input quat_y, input quat_z,
                 input quat_w, output ready);
endinterface

`default_nettype wire

FILE: hdl/euler_to_quaternion.sv
// Pipelined conversion of X, Y, Z rotation angles to a unit quaternion.
//
// One angle triple is taken per beat and one quaternion leaves per beat, and a new
// beat may enter in every cycle unless every stage is full and the response is stalled.
// One stage clamps and halves the angles, one stage per CORDIC rotation computes the
// sine and cosine of all three half angles in parallel, two multiplier stages with a
// rounding stage between them form the triple products, and the last stage adds,
// rounds and saturates into the output register. Each stage holds its beat only while
// the stage after it is full and stalled, so bubbles are squeezed out under
// back pressure and a stalled response stops new requests only once every stage is full.
`default_nettype none

module euler_to_quaternion import e2q_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int OUT_FRAC_BITS   = 14,
   parameter int CORDIC_STEPS    = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   e2q_req_if.sink    req_bus,
   e2q_rsp_if.source  rsp_bus
);

   localparam int NumRot = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int StgM1  = NumRot + 1;
   localparam int StgRnd = NumRot + 2;
   localparam int StgM2  = NumRot + 3;
   localparam int StgOut = NumRot + 4;
   localparam int NumStg = NumRot + 5;

   localparam logic signed [63:0] PiQ64 =
      (PI_Q60 + (64'sd1 <<< (59 - ANGLE_FRAC_BITS))) >>> (60 - ANGLE_FRAC_BITS);
   localparam logic signed [31:0] PiQ = PiQ64[31:0];
   localparam int HalfShift = 29 - ANGLE_FRAC_BITS;
   localparam prod_type ProdHalf = 64'sd1 <<< (Q_FRAC - 1);
   localparam int OutShift = 60 - OUT_FRAC_BITS;
   localparam sum_type OutHalf = 65'sd1 <<< (OutShift - 1);
   localparam int OutOne = 1 << OUT_FRAC_BITS;
   localparam int OutHi = (OutOne > 32767) ? 32767 : OutOne;
   localparam int OutLo = (-OutOne < -32768) ? -32768 : -OutOne;

   function automatic quat_type round_sat(input sum_type total);
      sum_type r;
      quat_type q;
      r = (total + OutHalf) >>> OutShift;
      if (r > SUM_W'(OutHi)) begin
         q = QUAT_W'(OutHi);
      end else if (r < SUM_W'(OutLo)) begin
         q = QUAT_W'(OutLo);
      end else begin
         q = r[QUAT_W-1:0];
      end
      return q;
   endfunction

   logic [NumStg-1:0] valid_ff;
   logic [NumStg-1:0] valid_in;
   logic [NumStg:0]   load;

   always_comb begin
      load[NumStg] = rsp_bus.ready;
      for (int k = NumStg - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = load[0] ? req_bus.valid : valid_ff[0];
      for (int k = 1; k < NumStg; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = load[0];
   assign rsp_bus.valid = valid_ff[StgOut];

   // CORDIC pipeline: entry 0 is the clamped half angle, entry k is after k rotations.
   cordic_type rx_ff [NumRot+1][NUM_LANES];
   cordic_type ry_ff [NumRot+1][NUM_LANES];
   cordic_type rz_ff [NumRot+1][NUM_LANES];
   cordic_type rx_in [NumRot+1][NUM_LANES];
   cordic_type ry_in [NumRot+1][NUM_LANES];
   cordic_type rz_in [NumRot+1][NUM_LANES];
   angle_type  angle [NUM_LANES];

   assign angle[LANE_X] = req_bus.angle_x;
   assign angle[LANE_Y] = req_bus.angle_y;
   assign angle[LANE_Z] = req_bus.angle_z;

   always_comb begin
      logic signed [31:0] a;
      cordic_type dx;
      cordic_type dy;
      cordic_type step;
      for (int l = 0; l < NUM_LANES; l++) begin
         a = 32'(angle[l]);
         if (a > PiQ) begin
            a = PiQ;
         end else if (a < -PiQ) begin
            a = -PiQ;
         end
         rx_in[0][l] = INV_GAIN_Q30;
         ry_in[0][l] = '0;
         rz_in[0][l] = CORDIC_W'(a) <<< HalfShift;
      end
      for (int k = 1; k <= NumRot; k++) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            dx   = ry_ff[k-1][l] >>> (k - 1);
            dy   = rx_ff[k-1][l] >>> (k - 1);
            step = CORDIC_W'(ATAN_Q30[k-1]);
            if (!rz_ff[k-1][l][CORDIC_W-1]) begin
               rx_in[k][l] = rx_ff[k-1][l] - dx;
               ry_in[k][l] = ry_ff[k-1][l] + dy;
               rz_in[k][l] = rz_ff[k-1][l] - step;
            end else begin
               rx_in[k][l] = rx_ff[k-1][l] + dx;
               ry_in[k][l] = ry_ff[k-1][l] - dy;
               rz_in[k][l] = rz_ff[k-1][l] + step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NumRot; k++) begin
         if (load[k]) begin
            rx_ff[k] <= rx_in[k];
            ry_ff[k] <= ry_in[k];
            rz_ff[k] <= rz_in[k];
         end
      end
   end

   mul_type cx, sx, cy, sy, cz, sz;

   assign cx = rx_ff[NumRot][LANE_X][MUL_W-1:0];
   assign sx = ry_ff[NumRot][LANE_X][MUL_W-1:0];
   assign cy = rx_ff[NumRot][LANE_Y][MUL_W-1:0];
   assign sy = ry_ff[NumRot][LANE_Y][MUL_W-1:0];
   assign cz = rx_ff[NumRot][LANE_Z][MUL_W-1:0];
   assign sz = ry_ff[NumRot][LANE_Z][MUL_W-1:0];

   // First products of the X and Y terms, Q60.
   prod_type sxcy_ff, cxsy_ff, cxcy_ff, sxsy_ff;
   mul_type  cz_m1_ff, sz_m1_ff;

   always_ff @(posedge clock) begin
      if (load[StgM1]) begin
         sxcy_ff  <= PROD_W'(sx) * PROD_W'(cy);
         cxsy_ff  <= PROD_W'(cx) * PROD_W'(sy);
         cxcy_ff  <= PROD_W'(cx) * PROD_W'(cy);
         sxsy_ff  <= PROD_W'(sx) * PROD_W'(sy);
         cz_m1_ff <= cz;
         sz_m1_ff <= sz;
      end
   end

   mul_type sxcy_r_ff, cxsy_r_ff, cxcy_r_ff, sxsy_r_ff;
   mul_type cz_r_ff, sz_r_ff;

   always_ff @(posedge clock) begin
      if (load[StgRnd]) begin
         sxcy_r_ff <= MUL_W'((sxcy_ff + ProdHalf) >>> Q_FRAC);
         cxsy_r_ff <= MUL_W'((cxsy_ff + ProdHalf) >>> Q_FRAC);
         cxcy_r_ff <= MUL_W'((cxcy_ff + ProdHalf) >>> Q_FRAC);
         sxsy_r_ff <= MUL_W'((sxsy_ff + ProdHalf) >>> Q_FRAC);
         cz_r_ff   <= cz_m1_ff;
         sz_r_ff   <= sz_m1_ff;
      end
   end

   prod_type tx_pos_ff, tx_neg_ff, ty_pos_ff, ty_neg_ff;
   prod_type tz_pos_ff, tz_neg_ff, tw_pos_ff, tw_neg_ff;

   always_ff @(posedge clock) begin
      if (load[StgM2]) begin
         tx_pos_ff <= PROD_W'(sxcy_r_ff) * PROD_W'(cz_r_ff);
         tx_neg_ff <= PROD_W'(cxsy_r_ff) * PROD_W'(sz_r_ff);
         ty_pos_ff <= PROD_W'(cxsy_r_ff) * PROD_W'(cz_r_ff);
         ty_neg_ff <= PROD_W'(sxcy_r_ff) * PROD_W'(sz_r_ff);
         tz_pos_ff <= PROD_W'(cxcy_r_ff) * PROD_W'(sz_r_ff);
         tz_neg_ff <= PROD_W'(sxsy_r_ff) * PROD_W'(cz_r_ff);
         tw_pos_ff <= PROD_W'(cxcy_r_ff) * PROD_W'(cz_r_ff);
         tw_neg_ff <= PROD_W'(sxsy_r_ff) * PROD_W'(sz_r_ff);
      end
   end

   quat_type quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;

   always_ff @(posedge clock) begin
      if (load[StgOut]) begin
         quat_x_ff <= round_sat(SUM_W'(tx_pos_ff) - SUM_W'(tx_neg_ff));
         quat_y_ff <= round_sat(SUM_W'(ty_pos_ff) + SUM_W'(ty_neg_ff));
         quat_z_ff <= round_sat(SUM_W'(tz_pos_ff) - SUM_W'(tz_neg_ff));
         quat_w_ff <= round_sat(SUM_W'(tw_pos_ff) + SUM_W'(tw_neg_ff));
      end
   end

   assign rsp_bus.quat_x = quat_x_ff;
   assign rsp_bus.quat_y = quat_y_ff;
   assign rsp_bus.quat_z = quat_z_ff;
   assign rsp_bus.quat_w = quat_w_ff;

endmodule

`default_nettype wire

FILE: hdl/e2q_checker.sv
// Port-level checks of the Euler angle to quaternion converter and their binding.
`default_nettype none

module e2q_checker import e2q_pkg::*; #(
   parameter int OUT_FRAC_BITS = 14
) (
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_ready,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire quat_type quat_x,
   input wire quat_type quat_y,
   input wire quat_type quat_z,
   input wire quat_type quat_w
);

   localparam int OutOne = 1 << OUT_FRAC_BITS;
   localparam quat_type QHi = QUAT_W'((OutOne > 32767) ? 32767 : OutOne);
   localparam quat_type QLo = QUAT_W'((-OutOne < -32768) ? -32768 : -OutOne);

   // Reset empties the pipeline, so no response beat shows right after it.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat valid right after reset");

   // A free output stage lets the whole pipeline move, so requests are taken.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request not ready while output stage can drain");

   // Every component is saturated to the unit range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (quat_x <= QHi) && (quat_x >= QLo) && (quat_y <= QHi) &&
                    (quat_y >= QLo) && (quat_z <= QHi) && (quat_z >= QLo) &&
                    (quat_w <= QHi) && (quat_w >= QLo))
      else $error("quaternion component outside the unit range");

   // A stalled response beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(quat_x) && $stable(quat_y) &&
                                  $stable(quat_z) && $stable(quat_w))
      else $error("stalled response beat changed");

endmodule

bind euler_to_quaternion e2q_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_e2q_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .quat_x    (rsp_bus.quat_x),
   .quat_y    (rsp_bus.quat_y),
   .quat_z    (rsp_bus.quat_z),
   .quat_w    (rsp_bus.quat_w)
);

`default_nettype wire

FILE: tb/euler_to_quaternion_tb.sv
// Self-checking testbench for the Euler angle to quaternion converter.
module euler_to_quaternion_tb import e2q_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_FRAC_BITS = 13;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int CORDIC_STEPS    = 16;
   localparam int LATENCY         = (CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS) + 5;
   localparam int RANDOM_BEATS    = 1300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int ANGLE_PI        = 25736;

   typedef struct {
      quat_type x;
      quat_type y;
      quat_type z;
      quat_type w;
   } quat_beat_type;

   class quat_scoreboard;
      localparam longint PI_Q60 = 64'sh3243F6A8885A308D;
      localparam longint INV_GAIN_Q30 = 652032874;
      localparam longint ARCTAN_Q30 [24] = '{
         843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
         16775851, 8388437, 4194283, 2097149, 1048576, 524288,
         262144, 131072, 65536, 32768, 16384, 8192,
         4096, 2048, 1024, 512, 256, 128
      };

      quat_beat_type expected_quats[$];
      int mismatches = 0;

      function longint half_angle_q30(angle_type raw);
         longint pi_q;
         longint a;
         pi_q = (PI_Q60 + (longint'(1) << (59 - ANGLE_FRAC_BITS))) >>> (60 - ANGLE_FRAC_BITS);
         a = longint'(raw);
         if (a > pi_q) a = pi_q;
         if (a < -pi_q) a = -pi_q;
         return a * (longint'(1) << (29 - ANGLE_FRAC_BITS));
      endfunction

      function void rotate(longint z, output longint c, output longint s);
         longint x;
         longint y;
         longint dx;
         longint dy;
         int steps;
         x = INV_GAIN_Q30;
         y = 0;
         steps = CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS;
         for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= ARCTAN_Q30[i];
            end else begin
               x += dx;
               y -= dy;
               z += ARCTAN_Q30[i];
            end
         end
         c = x;
         s = y;
      endfunction

      function longint triple_product(longint a, longint b, longint c);
         longint ab;
         ab = (a * b + (longint'(1) << 29)) >>> 30;
         return ab * c;
      endfunction

      function quat_type round_saturate(longint q60);
         longint r;
         longint one;
         r = (q60 + (longint'(1) << (59 - OUT_FRAC_BITS))) >>> (60 - OUT_FRAC_BITS);
         one = longint'(1) << OUT_FRAC_BITS;
         if (r > one) r = one;
         if (r < -one) r = -one;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return quat_type'(r);
      endfunction

      function void note_angles(angle_type ax, angle_type ay, angle_type az);
         longint cx, sx, cy, sy, cz, sz;
         quat_beat_type q;
         rotate(half_angle_q30(ax), cx, sx);
         rotate(half_angle_q30(ay), cy, sy);
         rotate(half_angle_q30(az), cz, sz);
         q.x = round_saturate(triple_product(sx, cy, cz) - triple_product(cx, sy, sz));
         q.y = round_saturate(triple_product(cx, sy, cz) + triple_product(sx, cy, sz));
         q.z = round_saturate(triple_product(cx, cy, sz) - triple_product(sx, sy, cz));
         q.w = round_saturate(triple_product(cx, cy, cz) + triple_product(sx, sy, sz));
         expected_quats.push_back(q);
      endfunction

      function void check_quat(quat_beat_type got);
         quat_beat_type want;
         if (expected_quats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected quaternion beat x=%0d y=%0d z=%0d w=%0d",
                        got.x, got.y, got.z, got.w);
            return;
         end
         want = expected_quats.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.w !== want.w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Quaternion mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                        want.x, want.y, want.z, want.w, got.x, got.y, got.z, got.w);
         end
      endfunction

      function int pending();
         return expected_quats.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic no_idle;
   int unsigned cycles = 0;
   quat_scoreboard sb = new;

   e2q_req_if req_bus ();
   e2q_rsp_if rsp_bus ();

   euler_to_quaternion #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS(OUT_FRAC_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock) begin
      quat_beat_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.x = rsp_bus.quat_x;
         got.y = rsp_bus.quat_y;
         got.z = rsp_bus.quat_z;
         got.w = rsp_bus.quat_w;
         sb.check_quat(got);
      end
   end

   task automatic send_angles(input angle_type ax, input angle_type ay, input angle_type az);
      if (!no_idle && $urandom_range(0, 99) < 25) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.angle_x <= ax;
      req_bus.angle_y <= ay;
      req_bus.angle_z <= az;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_angles(ax, ay, az);
   endtask

   function automatic angle_type pick_angle();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 75)
         return angle_type'($urandom_range(0, 2 * ANGLE_PI) - ANGLE_PI);
      else if (kind < 88)
         return angle_type'($urandom_range(0, 65535));
      else if (kind < 94)
         return angle_type'(($urandom_range(0, 1) ? ANGLE_PI : -ANGLE_PI)
                            + $urandom_range(0, 8) - 4);
      else
         return angle_type'($urandom_range(0, 16) - 8);
   endfunction

   initial begin
      int directed [16][3] = '{
         '{0, 0, 0}, '{ANGLE_PI, 0, 0}, '{0, -ANGLE_PI, 0}, '{0, 0, ANGLE_PI},
         '{ANGLE_PI, ANGLE_PI, ANGLE_PI}, '{-ANGLE_PI, -ANGLE_PI, -ANGLE_PI},
         '{32767, 32767, 32767}, '{-32768, -32768, -32768},
         '{ANGLE_PI + 1, -ANGLE_PI - 1, 0}, '{12868, 12868, 12868},
         '{-12868, 12868, -12868}, '{1, -1, 1}, '{-1, 0, 32767},
         '{12868, 0, -32768}, '{-ANGLE_PI, 12868, ANGLE_PI}, '{6434, -19302, 3217}
      };
      reset <= 1'b1;
      no_idle <= 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.angle_x <= '0;
      req_bus.angle_y <= '0;
      req_bus.angle_z <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_angles(angle_type'(directed[i][0]), angle_type'(directed[i][1]),
                     angle_type'(directed[i][2]));

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         no_idle <= (n >= 500 && n < 800);
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end

      req_bus.valid <= 1'b0;
      no_idle <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
